// ----- src/dfst_pkg.sv -----
// dfst_pkg: shared constants and byte helpers for the field splitter.
// Used by delimited_field_splitter_trim and its port checker.
// No dependencies.
`default_nettype none

package dfst_pkg;

	localparam int PADDR_W = 4;

	localparam logic [1:0] REG_DELIM = 2'd0;
	localparam logic [1:0] REG_GROUP = 2'd1;
	localparam logic [1:0] REG_TRIM  = 2'd2;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam logic [1:0] WS_SPACE = 2'd0;
	localparam logic [1:0] WS_TAB   = 2'd1;
	localparam logic [1:0] WS_LF    = 2'd2;
	localparam logic [1:0] WS_CR    = 2'd3;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

	function automatic logic [1:0] ws_code(input logic [7:0] c);
		logic [1:0] r;
		r = WS_SPACE;
		if (c == CH_TAB)
			r = WS_TAB;
		else if (c == CH_LF)
			r = WS_LF;
		else if (c == CH_CR)
			r = WS_CR;
		return r;
	endfunction

	function automatic logic [7:0] ws_byte(input logic [1:0] code);
		logic [7:0] r;
		case (code)
			WS_SPACE: r = CH_SPACE;
			WS_TAB:   r = CH_TAB;
			WS_LF:    r = CH_LF;
			WS_CR:    r = CH_CR;
			default:  r = CH_SPACE;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- src/delimited_field_splitter_trim.sv -----
// The first word of an item is registered from the held item state once the item is
// accepted; a held whitespace byte read back first also passes the memory read register.
// Output: one word a cycle while the output takes them. A new item is not taken until the
// last word of the previous item is loaded into the output register, and output stalls
// delay that; an item that yields no words does not hold off the next one.
// Reset clears control state and presets config registers; whitespace memory is not cleared.
`default_nettype none

module delimited_field_splitter_trim #(
	parameter int PENDING_WS_MAX = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dfst_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   ch,
	input  logic                         end_of_string,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   kind,
	output logic [7:0]                   data,
	output logic                         ws_overflow,
	output logic                         final_field,
	output logic                         last
);
	import dfst_pkg::*;

	localparam int CW = $clog2(PENDING_WS_MAX + 1);
	localparam int AW = (PENDING_WS_MAX > 1) ? $clog2(PENDING_WS_MAX) : 1;
	localparam logic [CW-1:0] MAXC = CW'(PENDING_WS_MAX);

	logic [7:0]    delim_q;
	logic          group_q;
	logic          trim_q;

	logic          in_group_q;
	logic          seen_q;
	logic [CW-1:0] count_q;
	logic          rovf_q;

	logic [1:0]    pend_ws_q [PENDING_WS_MAX];

	logic          busy_q;
	logic [CW-1:0] flush_n_q;
	logic [CW-1:0] rd_idx_q;
	logic          mid_pend_q;
	logic [1:0]    mid_kind_q;
	logic [7:0]    mid_data_q;
	logic          mid_ovf_q;
	logic          tail_pend_q;
	logic [1:0]    tail_kind_q;
	logic          tail_ovf_q;
	logic          wr_pend_q;
	logic [1:0]    wr_code_q;

	logic          rd_valid_s1;
	logic          rd_last_s1;
	logic [1:0]    rd_code_s1;

	logic          out_valid_q;
	logic [1:0]    kind_q;
	logic [7:0]    data_q;
	logic          ovf_q;
	logic          fin_q;
	logic          last_q;

	logic          has_c, is_delim, grp_nx, ws_path, hold, ovf_flush, data_path, mid_any;
	logic          seen_a, rovf_a, grp_a, n_any, acc, cfg_wr;
	logic [CW-1:0] flush_n, count_a;
	logic          out_free, s1_adv, rd_issue, rd_last, rd_done;
	logic          ld_flush, ld_mid, ld_tail, seq_end;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [1:0]    mem_wd;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign in_ready  = !busy_q;
	assign acc       = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign kind        = kind_q;
	assign data        = data_q;
	assign ws_overflow = ovf_q;
	assign final_field = fin_q;
	assign last        = last_q;

	always_comb begin
		case (paddr[PADDR_W-1:2])
			REG_DELIM: prdata = {24'd0, delim_q};
			REG_GROUP: prdata = {31'd0, group_q};
			REG_TRIM:  prdata = {31'd0, trim_q};
			default:   prdata = 32'd0;
		endcase
	end

	always_comb begin
		has_c    = ch != 8'd0;
		is_delim = has_c && !in_group_q && (ch == delim_q);
		grp_nx   = in_group_q;
		if (has_c && !is_delim) begin
			if (in_group_q) begin
				if (ch == CH_RPAREN)
					grp_nx = 1'b0;
			end else if (group_q && ch == CH_LPAREN) begin
				grp_nx = 1'b1;
			end
		end
		ws_path   = has_c && !is_delim && trim_q && is_ws(ch);
		hold      = ws_path && seen_q;
		ovf_flush = hold && (count_q >= MAXC);
		data_path = has_c && !is_delim && !ws_path;
		flush_n   = data_path ? count_q : (ovf_flush ? MAXC : '0);

		seen_a  = seen_q;
		count_a = count_q;
		rovf_a  = rovf_q;
		grp_a   = grp_nx;
		if (is_delim) begin
			seen_a  = 1'b0;
			count_a = '0;
			rovf_a  = 1'b0;
			grp_a   = 1'b0;
		end else if (hold) begin
			count_a = ovf_flush ? CW'(1) : count_q + 1'b1;
			if (ovf_flush)
				rovf_a = 1'b1;
		end else if (data_path) begin
			seen_a  = 1'b1;
			count_a = '0;
			rovf_a  = 1'b0;
		end
		mid_any = is_delim || data_path;
		n_any   = mid_any || end_of_string || (flush_n != '0);
	end

	always_comb begin
		out_free = !out_valid_q || out_ready;
		s1_adv   = !rd_valid_s1 || out_free;
		rd_done  = rd_idx_q == flush_n_q;
		rd_issue = busy_q && !rd_done && s1_adv;
		rd_last  = ((rd_idx_q + 1'b1) == flush_n_q) && !mid_pend_q && !tail_pend_q;
		ld_flush = out_free && rd_valid_s1;
		ld_mid   = out_free && !rd_valid_s1 && busy_q && rd_done && mid_pend_q;
		ld_tail  = out_free && !rd_valid_s1 && busy_q && rd_done && !mid_pend_q
			&& tail_pend_q;
		seq_end  = (ld_flush && rd_last_s1) || (ld_mid && !tail_pend_q) || ld_tail;

		mem_we = 1'b0;
		mem_wa = count_q[AW-1:0];
		mem_wd = ws_code(ch);
		if (acc && hold && !ovf_flush) begin
			mem_we = 1'b1;
		end else if (busy_q && wr_pend_q && rd_done) begin
			mem_we = 1'b1;
			mem_wa = '0;
			mem_wd = wr_code_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			pend_ws_q[mem_wa] <= mem_wd;
		if (rd_issue) begin
			rd_code_s1 <= pend_ws_q[rd_idx_q[AW-1:0]];
			rd_last_s1 <= rd_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q     <= CH_COMMA;
			group_q     <= 1'b1;
			trim_q      <= 1'b1;
			in_group_q  <= 1'b0;
			seen_q      <= 1'b0;
			count_q     <= '0;
			rovf_q      <= 1'b0;
			busy_q      <= 1'b0;
			flush_n_q   <= '0;
			rd_idx_q    <= '0;
			mid_pend_q  <= 1'b0;
			tail_pend_q <= 1'b0;
			wr_pend_q   <= 1'b0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[PADDR_W-1:2])
					REG_DELIM: delim_q <= pwdata[7:0];
					REG_GROUP: group_q <= pwdata[0];
					REG_TRIM:  trim_q  <= pwdata[0];
					default:   ;
				endcase
			end

			if (acc) begin
				if (end_of_string) begin
					in_group_q <= 1'b0;
					seen_q     <= 1'b0;
					count_q    <= '0;
					rovf_q     <= 1'b0;
				end else begin
					in_group_q <= grp_a;
					seen_q     <= seen_a;
					count_q    <= count_a;
					rovf_q     <= rovf_a;
				end
				busy_q      <= n_any;
				flush_n_q   <= flush_n;
				rd_idx_q    <= '0;
				mid_pend_q  <= mid_any;
				tail_pend_q <= end_of_string;
				wr_pend_q   <= ovf_flush;
			end else begin
				if (rd_issue)
					rd_idx_q <= rd_idx_q + 1'b1;
				if (ld_mid)
					mid_pend_q <= 1'b0;
				if (ld_tail)
					tail_pend_q <= 1'b0;
				if (mem_we)
					wr_pend_q <= 1'b0;
				if (seq_end)
					busy_q <= 1'b0;
			end

			if (rd_issue)
				rd_valid_s1 <= 1'b1;
			else if (ld_flush)
				rd_valid_s1 <= 1'b0;

			if (ld_flush || ld_mid || ld_tail)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mid_kind_q  <= is_delim ? KIND_END : KIND_DATA;
			mid_data_q  <= is_delim ? 8'd0 : ch;
			mid_ovf_q   <= is_delim && rovf_q;
			tail_kind_q <= grp_a ? KIND_ERR : KIND_END;
			tail_ovf_q  <= !grp_a && rovf_a;
			wr_code_q   <= ws_code(ch);
		end
		if (ld_flush) begin
			kind_q <= KIND_DATA;
			data_q <= ws_byte(rd_code_s1);
			ovf_q  <= 1'b0;
			fin_q  <= 1'b0;
			last_q <= rd_last_s1;
		end else if (ld_mid) begin
			kind_q <= mid_kind_q;
			data_q <= mid_data_q;
			ovf_q  <= mid_ovf_q;
			fin_q  <= 1'b0;
			last_q <= !tail_pend_q;
		end else if (ld_tail) begin
			kind_q <= tail_kind_q;
			data_q <= 8'd0;
			ovf_q  <= tail_ovf_q;
			fin_q  <= 1'b1;
			last_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- src/dfst_chk.sv -----
// dfst_chk: port-level checks on the result channel of the field splitter.
// Depends on dfst_pkg; bound to delimited_field_splitter_trim below.
`default_nettype none

module dfst_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [7:0] data,
	input logic       ws_overflow,
	input logic       final_field,
	input logic       last
);
	import dfst_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data)
			&& $stable(last) && $stable(final_field))
		else $error("result word changed while stalled");

	a_marks_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_DATA |-> data == 8'd0)
		else $error("field end or error carries data");

	a_ovf_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ws_overflow |-> kind == KIND_END)
		else $error("overflow flag outside field end");

	a_final_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && final_field |-> last && (kind == KIND_END || kind == KIND_ERR))
		else $error("final field word not last or not a mark");

endmodule

bind delimited_field_splitter_trim dfst_chk u_dfst_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.kind        (kind),
	.data        (data),
	.ws_overflow (ws_overflow),
	.final_field (final_field),
	.last        (last)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench for delimited_field_splitter_trim.
// Drives strings through the valid/ready input, sets registers over APB and compares every
// output word with a field splitter predictor kept here; depends on dfst_pkg and the DUT.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dfst_pkg::*;

	localparam int HOLD_MAX = 32;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       ovf;
		logic       fin;
		logic       last;
	} token_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           ch;
	logic                 end_of_string;
	logic                 out_valid;
	logic                 out_ready;
	logic [1:0]           kind;
	logic [7:0]           data;
	logic                 ws_overflow;
	logic                 final_field;
	logic                 last;

	// splitter state as predicted
	logic [7:0] cfg_delim;
	logic       cfg_group;
	logic       cfg_trim;
	logic       in_paren;
	logic       got_text;
	logic       run_spilled;
	logic [7:0] held_ws[$];

	token_t token_q[$];
	int     mismatches;
	int     items_sent;
	logic   in_no_idle;
	logic   out_no_idle;

	delimited_field_splitter_trim DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.end_of_string(end_of_string),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data(data),
		.ws_overflow(ws_overflow),
		.final_field(final_field),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic token_t make_tok(input logic [1:0] k, input logic [7:0] d,
			input logic o, input logic f);
		token_t t;
		t.kind = k;
		t.data = d;
		t.ovf = o;
		t.fin = f;
		t.last = 1'b0;
		return t;
	endfunction

	function automatic void clear_field();
		in_paren = 1'b0;
		got_text = 1'b0;
		run_spilled = 1'b0;
		held_ws.delete();
	endfunction

	function automatic void split_byte(input logic [7:0] c, input logic eos);
		token_t words[$];
		token_t t;
		logic   is_ws;
		if (c != 8'h00) begin
			if (!in_paren && c == cfg_delim) begin
				words.push_back(make_tok(KIND_END, 8'h00, run_spilled, 1'b0));
				clear_field();
			end else begin
				if (in_paren) begin
					if (c == CH_RPAREN)
						in_paren = 1'b0;
				end else if (cfg_group && c == CH_LPAREN) begin
					in_paren = 1'b1;
				end
				is_ws = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
				if (cfg_trim && is_ws) begin
					if (got_text) begin
						if (held_ws.size() >= HOLD_MAX) begin
							while (held_ws.size() > 0)
								words.push_back(make_tok(KIND_DATA, held_ws.pop_front(), 1'b0, 1'b0));
							run_spilled = 1'b1;
						end
						held_ws.push_back(c);
					end
				end else begin
					got_text = 1'b1;
					while (held_ws.size() > 0)
						words.push_back(make_tok(KIND_DATA, held_ws.pop_front(), 1'b0, 1'b0));
					words.push_back(make_tok(KIND_DATA, c, 1'b0, 1'b0));
					run_spilled = 1'b0;
				end
			end
		end
		if (eos) begin
			if (in_paren)
				words.push_back(make_tok(KIND_ERR, 8'h00, 1'b0, 1'b1));
			else
				words.push_back(make_tok(KIND_END, 8'h00, run_spilled, 1'b1));
			clear_field();
		end
		if (words.size() > 0) begin
			t = words.pop_back();
			t.last = 1'b1;
			words.push_back(t);
		end
		foreach (words[i])
			token_q.push_back(words[i]);
	endfunction

	always @(posedge clk) begin
		token_t want;
		if (arst_n && out_valid && out_ready) begin
			if (token_q.size() == 0) begin
				$error("unexpected word: kind %0d data %02h", kind, data);
				mismatches++;
			end else begin
				want = token_q.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					mismatches++;
				end
				if (data !== want.data) begin
					$error("data: expected %02h, got %02h", want.data, data);
					mismatches++;
				end
				if (ws_overflow !== want.ovf) begin
					$error("ws_overflow: expected %0b, got %0b", want.ovf, ws_overflow);
					mismatches++;
				end
				if (final_field !== want.fin) begin
					$error("final_field: expected %0b, got %0b", want.fin, final_field);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					mismatches++;
				end
			end
		end
	end

	// output backpressure: a random stall, possibly none, before each word unless out_no_idle
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = out_no_idle ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_byte(input logic [7:0] c, input logic eos);
		int gap;
		gap = in_no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		split_byte(c, eos);
		in_valid <= 1'b1;
		ch <= c;
		end_of_string <= eos;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (token_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_DELIM: cfg_delim = val[7:0];
			REG_GROUP: cfg_group = val[0];
			REG_TRIM:  cfg_trim = val[0];
			default:   ;
		endcase
	endtask

	function automatic logic [7:0] pick_ws();
		case ($urandom_range(0, 3))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			2:       return CH_LF;
			default: return CH_CR;
		endcase
	endfunction

	task automatic send_random_string();
		int len;
		int r;
		int run;
		in_no_idle = ($urandom_range(0, 3) == 0);
		out_no_idle = ($urandom_range(0, 3) == 0);
		len = $urandom_range(0, 10);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 38)
				send_byte(8'($urandom_range(1, 255)), 1'b0);
			else if (r < 50)
				send_byte((cfg_delim != 8'h00) ? cfg_delim : CH_COMMA, 1'b0);
			else if (r < 58)
				send_byte(CH_LPAREN, 1'b0);
			else if (r < 66)
				send_byte(CH_RPAREN, 1'b0);
			else if (r < 86)
				send_byte(pick_ws(), 1'b0);
			else if (r < 92) begin
				// long whitespace run, around the hold buffer size
				run = $urandom_range(28, 40);
				repeat (run) send_byte(pick_ws(), 1'b0);
			end else if (r < 96)
				send_byte(8'h00, 1'b0);
			else
				send_byte(8'($urandom_range(0, 255)), 1'b0);
		end
		r = $urandom_range(0, 5);
		if (r == 0)
			send_byte(8'h00, 1'b1);
		else if (r == 1)
			send_byte(pick_ws(), 1'b1);
		else if (r == 2)
			send_byte((cfg_delim != 8'h00) ? cfg_delim : CH_COMMA, 1'b1);
		else
			send_byte(8'($urandom_range(1, 255)), 1'b1);
	endtask

	task automatic test_directed();
		send_byte(CH_SPACE, 1'b0);
		send_byte("a", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte(CH_COMMA, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(CH_LPAREN, 1'b0);
		send_byte("x", 1'b0);
		send_byte(CH_COMMA, 1'b0);
		send_byte(CH_LPAREN, 1'b0);
		send_byte(CH_RPAREN, 1'b0);
		send_byte(CH_RPAREN, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte("b", 1'b1);
		send_byte(CH_COMMA, 1'b1);
		send_byte(CH_LPAREN, 1'b0);
		send_byte("q", 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b1);
		send_byte(8'h01, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(CH_SPACE, 1'b1);
	endtask

	task automatic test_reconfig_mid_field();
		send_byte("a", 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_byte(CH_TAB, 1'b0);
		cfg_write(REG_TRIM, 32'd0);
		send_byte("b", 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_byte(CH_COMMA, 1'b0);
		cfg_write(REG_TRIM, 32'd1);
		send_byte(CH_LPAREN, 1'b0);
		cfg_write(REG_GROUP, 32'd0);
		send_byte(CH_COMMA, 1'b0);
		send_byte(CH_RPAREN, 1'b0);
		send_byte(CH_COMMA, 1'b1);
		cfg_write(REG_GROUP, 32'd1);
		cfg_write(REG_DELIM, {24'd0, CH_LPAREN});
		send_byte("x", 1'b0);
		send_byte(CH_LPAREN, 1'b0);
		send_byte("y", 1'b1);
		cfg_write(REG_DELIM, {24'd0, CH_COMMA});
	endtask

	task automatic run_phase(input logic [7:0] d, input logic g, input logic t, input int budget);
		int stop_at;
		cfg_write(REG_DELIM, {24'd0, d});
		cfg_write(REG_GROUP, {31'd0, g});
		cfg_write(REG_TRIM, {31'd0, t});
		stop_at = items_sent + budget;
		while (items_sent < stop_at)
			send_random_string();
	endtask

	task automatic test_random_configs();
		run_phase(CH_COMMA, 1'b1, 1'b1, 40);
		run_phase(CH_COMMA, 1'b0, 1'b0, 35);
		run_phase(8'hFF, 1'b1, 1'b0, 35);
		run_phase(8'h00, 1'b0, 1'b1, 35);
		run_phase(CH_LPAREN, 1'b1, 1'b1, 35);
		run_phase(CH_SPACE, 1'b1, 1'b1, 35);
		run_phase(CH_TAB, 1'b0, 1'b1, 30);
		run_phase(8'($urandom_range(1, 255)), 1'b1, 1'b1, 30);
		run_phase(CH_COMMA, 1'b1, 1'b1, 30);
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		ch <= 8'h00;
		end_of_string <= 1'b0;
		cfg_delim = CH_COMMA;
		cfg_group = 1'b1;
		cfg_trim = 1'b1;
		clear_field();
		mismatches = 0;
		items_sent = 0;
		in_no_idle = 1'b0;
		out_no_idle = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_reconfig_mid_field();
		test_random_configs();

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && token_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/dfst_pkg.sv
src/delimited_field_splitter_trim.sv
src/dfst_chk.sv
tb/tb_top.sv
